// File: rtl/tfd_pkg.sv
// Shared types, constants and the CRC-8 step function for the telemetry frame decoder.
`timescale 1ns / 1ps
`default_nettype none

package tfd_pkg;

    localparam logic [7:0]  SYNC_RESET   = 8'hEA;
    localparam logic [7:0]  TYPE_GPS     = 8'h02;
    localparam logic [7:0]  TYPE_BATTERY = 8'h08;
    localparam logic [7:0]  NOT_PRESENT  = 8'hFF;
    localparam logic [7:0]  CRC_POLY     = 8'hD5;
    localparam logic [15:0] ALT_OFFSET   = 16'd1000;
    // ceil(2^35 / 10): exact floor(a / 10) for any 32-bit a via (a * R) >> 35
    localparam logic [31:0] DIV10_RECIP  = 32'hCCCC_CCCD;
    localparam int          DIV10_SHIFT  = 35;

    // Frame bytes at indexes 2..17 are the only ones the decode looks at
    localparam int FIELD_BASE  = 2;
    localparam int FIELD_BYTES = 16;

    localparam logic [1:0] FIX_NONE = 2'd0;
    localparam logic [1:0] FIX_2D   = 2'd2;
    localparam logic [1:0] FIX_3D   = 2'd3;

    typedef enum logic [1:0] {
        ST_GPS     = 2'd0,
        ST_BATTERY = 2'd1,
        ST_OTHER   = 2'd2,
        ST_CRC_ERR = 2'd3
    } frame_status_t;

    typedef logic [FIELD_BYTES-1:0][7:0] field_bytes_t;

    // Frame-complete event from the parser
    typedef struct packed {
        logic valid;
        logic crc_ok;
    } parse_evt_t;

    // Decoded fields of one finished frame
    typedef struct packed {
        logic          valid;
        logic          crc_ok;
        frame_status_t kind;
        logic          lat_present;
        logic          lat_neg;
        logic [28:0]   lat_mag;
        logic          lon_present;
        logic          lon_neg;
        logic [28:0]   lon_mag;
        logic          spd_present;
        logic [15:0]   spd;
        logic          crs_present;
        logic [15:0]   crs;
        logic          alt_present;
        logic [15:0]   alt;
        logic          sats_present;
        logic [7:0]    sats;
        logic          volt_present;
        logic [15:0]   volt;
    } dec_t;

    function automatic logic [7:0] tfd_crc8(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: rtl/tfd_parser.sv
// Byte parser: sync hunt, length check, running CRC and capture of the field bytes.
`timescale 1ns / 1ps
`default_nettype none

module tfd_parser #(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [7:0]            cfg_wdata,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [7:0]            byte_in,
    input  wire logic                  dec_ready,
    output tfd_pkg::parse_evt_t        evt,
    output tfd_pkg::field_bytes_t      fields
);
    import tfd_pkg::*;

    localparam int         CW      = $clog2(BUFFER_BYTES + 1);
    localparam logic [7:0] LEN_MAX = 8'(BUFFER_BYTES - 2);

    logic [7:0]    sync_reg;
    logic [CW-1:0] count_reg, count_next, count_inc, len_plus2;
    logic [7:0]    len_reg, len_next;
    logic [7:0]    crc_reg, crc_next;
    logic          ev_valid_reg, ev_valid_next;
    logic          ev_crc_ok_reg, ev_crc_ok_next;
    logic          fire, take;
    field_bytes_t  fb_reg;

    // A pending event must leave before a new byte can land behind it
    assign in_ready  = !ev_valid_reg || dec_ready;
    assign fire      = in_valid && in_ready;
    assign count_inc = count_reg + CW'(1);
    assign len_plus2 = CW'(len_reg) + CW'(2);

    always_comb
    begin
        count_next     = count_reg;
        len_next       = len_reg;
        crc_next       = crc_reg;
        ev_valid_next  = ev_valid_reg && !dec_ready;
        ev_crc_ok_next = ev_crc_ok_reg;
        take           = 1'b0;
        if (fire)
        begin
            priority if (count_reg == '0)
            begin
                // hunting: only the sync byte opens a frame
                if (byte_in == sync_reg)
                begin
                    take       = 1'b1;
                    count_next = count_inc;
                end
            end
            else if (count_reg == CW'(1))
            begin
                if (byte_in < 8'd2 || byte_in > LEN_MAX)
                begin
                    count_next = '0;
                end
                else
                begin
                    take       = 1'b1;
                    count_next = count_inc;
                    len_next   = byte_in;
                    crc_next   = 8'h00;
                end
            end
            else if (count_reg >= CW'(BUFFER_BYTES))
            begin
                count_next = '0;
            end
            else
            begin
                take       = 1'b1;
                count_next = count_inc;
                if (count_reg <= CW'(len_reg))
                begin
                    crc_next = tfd_crc8(crc_reg, byte_in);
                end
                if (count_inc > CW'(4) && count_inc == len_plus2)
                begin
                    // last byte is the CRC itself and is not folded in
                    count_next     = '0;
                    ev_valid_next  = 1'b1;
                    ev_crc_ok_next = (crc_reg == byte_in);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg      <= SYNC_RESET;
            count_reg     <= '0;
            len_reg       <= 8'h00;
            crc_reg       <= 8'h00;
            ev_valid_reg  <= 1'b0;
            ev_crc_ok_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sync_reg <= cfg_wdata;
            end
            count_reg     <= count_next;
            len_reg       <= len_next;
            crc_reg       <= crc_next;
            ev_valid_reg  <= ev_valid_next;
            ev_crc_ok_reg <= ev_crc_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < FIELD_BYTES; k++)
        begin
            if (take && count_reg == CW'(k + FIELD_BASE))
            begin
                fb_reg[k] <= byte_in;
            end
        end
    end

    assign evt.valid  = ev_valid_reg;
    assign evt.crc_ok = ev_crc_ok_reg;
    assign fields     = fb_reg;

    a_evt_held: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && !dec_ready) |=> ev_valid_reg)
        else $error("parser event dropped while decode stage was busy");

    a_block_behind_evt: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && !dec_ready) |-> !in_ready)
        else $error("byte accepted while a finished frame was waiting");

endmodule

`default_nettype wire

// File: rtl/tfd_decode.sv
// Decode stage: extracts fields of a finished frame, divides lat/lon by ten.
`timescale 1ns / 1ps
`default_nettype none

module tfd_decode (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire tfd_pkg::parse_evt_t   evt,
    input  wire tfd_pkg::field_bytes_t fields,
    output logic                       dec_ready,
    input  wire logic                  upd_ready,
    output tfd_pkg::dec_t              dec
);
    import tfd_pkg::*;

    logic        valid_reg;
    dec_t        dec_reg, dec_next;
    logic [31:0] lat_raw, lon_raw, lat_abs, lon_abs;
    logic [63:0] lat_prod, lon_prod;
    logic [15:0] volt_raw;

    assign dec_ready = !valid_reg || upd_ready;

    // field offsets are frame index minus FIELD_BASE
    assign lat_raw  = {fields[1], fields[2], fields[3], fields[4]};
    assign lon_raw  = {fields[5], fields[6], fields[7], fields[8]};
    assign lat_abs  = lat_raw[31] ? (~lat_raw + 32'd1) : lat_raw;
    assign lon_abs  = lon_raw[31] ? (~lon_raw + 32'd1) : lon_raw;
    assign lat_prod = {32'd0, lat_abs} * {32'd0, DIV10_RECIP};
    assign lon_prod = {32'd0, lon_abs} * {32'd0, DIV10_RECIP};
    assign volt_raw = {fields[1], fields[2]};

    always_comb
    begin
        dec_next        = '0;
        dec_next.valid  = evt.valid;
        dec_next.crc_ok = evt.crc_ok;
        priority if (fields[0] == TYPE_GPS)
        begin
            dec_next.kind = ST_GPS;
        end
        else if (fields[0] == TYPE_BATTERY)
        begin
            dec_next.kind = ST_BATTERY;
        end
        else
        begin
            dec_next.kind = ST_OTHER;
        end
        dec_next.lat_present  = (fields[1] != NOT_PRESENT);
        dec_next.lat_neg      = lat_raw[31];
        dec_next.lat_mag      = lat_prod[DIV10_SHIFT +: 29];
        dec_next.lon_present  = (fields[5] != NOT_PRESENT);
        dec_next.lon_neg      = lon_raw[31];
        dec_next.lon_mag      = lon_prod[DIV10_SHIFT +: 29];
        dec_next.spd_present  = (fields[9] != NOT_PRESENT);
        dec_next.spd          = {fields[9], fields[10]};
        dec_next.crs_present  = (fields[11] != NOT_PRESENT);
        dec_next.crs          = {fields[11], fields[12]};
        dec_next.alt_present  = (fields[13] != NOT_PRESENT);
        dec_next.alt          = {fields[13], fields[14]} - ALT_OFFSET;
        dec_next.sats_present = (fields[15] != NOT_PRESENT);
        dec_next.sats         = fields[15];
        dec_next.volt_present = (fields[1] != NOT_PRESENT);
        dec_next.volt         = (volt_raw << 3) + (volt_raw << 1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (dec_ready)
        begin
            valid_reg <= evt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dec_ready)
        begin
            dec_reg <= dec_next;
        end
    end

    always_comb
    begin
        dec       = dec_reg;
        dec.valid = valid_reg;
    end

endmodule

`default_nettype wire

// File: rtl/tfd_update.sv
// Update stage: held telemetry values, fix, position progress and the result register.
`timescale 1ns / 1ps
`default_nettype none

module tfd_update (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire tfd_pkg::dec_t  dec,
    output logic                upd_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          frame_status,
    output logic signed [28:0]  latitude,
    output logic signed [28:0]  longitude,
    output logic signed [15:0]  ground_speed,
    output logic signed [15:0]  heading,
    output logic [15:0]         altitude,
    output logic [7:0]          satellites,
    output logic [1:0]          fix_kind,
    output logic signed [15:0]  battery_voltage,
    output logic                position_done,
    output logic                altitude_updated,
    output logic [15:0]         crc_error_count
);
    import tfd_pkg::*;

    logic          fire;
    logic          out_valid_reg, out_valid_next;
    frame_status_t status_reg, status_next;
    logic          pos_pulse_reg, pos_pulse_next;
    logic          alt_pulse_reg, alt_pulse_next;
    logic [1:0]    prog_reg, prog_next;
    logic [28:0]   lat_reg, lat_next, lon_reg, lon_next;
    logic [15:0]   spd_reg, spd_next, crs_reg, crs_next, alt_reg, alt_next;
    logic [7:0]    sats_reg, sats_next;
    logic [1:0]    fix_reg, fix_next;
    logic [15:0]   volt_reg, volt_next;
    logic [15:0]   crc_cnt_reg, crc_cnt_next;

    // held values only move when the result slot frees, so they stay put while stalled
    assign upd_ready = !out_valid_reg || out_ready;
    assign fire      = dec.valid && upd_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        pos_pulse_next = pos_pulse_reg;
        alt_pulse_next = alt_pulse_reg;
        prog_next      = prog_reg;
        lat_next       = lat_reg;
        lon_next       = lon_reg;
        spd_next       = spd_reg;
        crs_next       = crs_reg;
        alt_next       = alt_reg;
        sats_next      = sats_reg;
        fix_next       = fix_reg;
        volt_next      = volt_reg;
        crc_cnt_next   = crc_cnt_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            pos_pulse_next = 1'b0;
            alt_pulse_next = 1'b0;
            if (!dec.crc_ok)
            begin
                status_next  = ST_CRC_ERR;
                crc_cnt_next = crc_cnt_reg + 16'd1;
            end
            else
            begin
                status_next = dec.kind;
                // fix comes from the count held before this frame
                priority if (sats_reg == 8'd0)
                begin
                    fix_next = FIX_NONE;
                end
                else if (sats_reg < 8'd5)
                begin
                    fix_next = FIX_2D;
                end
                else
                begin
                    fix_next = FIX_3D;
                end
                unique case (dec.kind)
                    ST_GPS:
                    begin
                        if (dec.lat_present)
                        begin
                            lat_next = dec.lat_neg ? (~dec.lat_mag + 29'd1) : dec.lat_mag;
                            if (prog_next == 2'd0)
                            begin
                                prog_next = 2'd1;
                            end
                        end
                        if (dec.lon_present)
                        begin
                            lon_next = dec.lon_neg ? (~dec.lon_mag + 29'd1) : dec.lon_mag;
                            if (prog_next == 2'd1)
                            begin
                                prog_next = 2'd2;
                            end
                        end
                        if (dec.spd_present)
                        begin
                            spd_next = dec.spd;
                        end
                        if (dec.crs_present)
                        begin
                            crs_next = dec.crs;
                        end
                        if (dec.alt_present)
                        begin
                            alt_next       = dec.alt;
                            alt_pulse_next = 1'b1;
                        end
                        if (dec.sats_present)
                        begin
                            sats_next = dec.sats;
                        end
                    end
                    ST_BATTERY:
                    begin
                        if (dec.volt_present)
                        begin
                            volt_next = dec.volt;
                        end
                    end
                    default:
                    begin
                    end
                endcase
                if (prog_next == 2'd2)
                begin
                    prog_next      = 2'd0;
                    pos_pulse_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_GPS;
            pos_pulse_reg <= 1'b0;
            alt_pulse_reg <= 1'b0;
            prog_reg      <= 2'd0;
            lat_reg       <= '0;
            lon_reg       <= '0;
            spd_reg       <= '0;
            crs_reg       <= '0;
            alt_reg       <= '0;
            sats_reg      <= '0;
            fix_reg       <= FIX_NONE;
            volt_reg      <= '0;
            crc_cnt_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            pos_pulse_reg <= pos_pulse_next;
            alt_pulse_reg <= alt_pulse_next;
            prog_reg      <= prog_next;
            lat_reg       <= lat_next;
            lon_reg       <= lon_next;
            spd_reg       <= spd_next;
            crs_reg       <= crs_next;
            alt_reg       <= alt_next;
            sats_reg      <= sats_next;
            fix_reg       <= fix_next;
            volt_reg      <= volt_next;
            crc_cnt_reg   <= crc_cnt_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign frame_status     = status_reg;
    assign latitude         = lat_reg;
    assign longitude        = lon_reg;
    assign ground_speed     = spd_reg;
    assign heading          = crs_reg;
    assign altitude         = alt_reg;
    assign satellites       = sats_reg;
    assign fix_kind         = fix_reg;
    assign battery_voltage  = volt_reg;
    assign position_done    = pos_pulse_reg;
    assign altitude_updated = alt_pulse_reg;
    assign crc_error_count  = crc_cnt_reg;

    a_crc_no_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg == ST_CRC_ERR) |-> !(pos_pulse_reg || alt_pulse_reg))
        else $error("pulse raised on a frame with a CRC error");

    a_crc_count_src: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(crc_cnt_reg) |-> $past(fire && !dec.crc_ok))
        else $error("CRC error count moved without a failing frame");

endmodule

`default_nettype wire

// File: rtl/telemetry_frame_decoder_core.sv
// Top level of the telemetry frame decoder: parser, decode and update stages.
//
// Usage:
//   Input channel (in_valid/in_ready/byte_in) carries one serial byte per
//   transaction, one per cycle if ready. Output channel (out_valid/out_ready)
//   carries one result per completed frame; the held values ride along.
//   cfg_we/cfg_wdata write the sync address (0xEA after reset), idle only.
//   The result of a frame travels from the transaction that carried its CRC
//   byte through the parser event register, the decode register and the
//   result register. The 32x32 reciprocal multiply for lat/lon sits
//   between the parser's field byte registers and the decode register.
//   Throughput: 1 byte per cycle unless stalled; at most 1 result per 5 bytes.
//   Stall: while out_ready is low, bytes keep flowing; in_ready drops only
//   when a finished frame is held in the parser behind a full decode stage
//   and a waiting result, and rises again in the cycle the result is taken.
//   Reset: count, CRC, held values, fix, progress and CRC error count clear;
//   no results are pending. Field byte storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module telemetry_frame_decoder_core #(
    parameter int BUFFER_BYTES = 128
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        byte_in,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [1:0]             frame_status,
    output logic signed [28:0]     latitude,
    output logic signed [28:0]     longitude,
    output logic signed [15:0]     ground_speed,
    output logic signed [15:0]     heading,
    output logic [15:0]            altitude,
    output logic [7:0]             satellites,
    output logic [1:0]             fix_kind,
    output logic signed [15:0]     battery_voltage,
    output logic                   position_done,
    output logic                   altitude_updated,
    output logic [15:0]            crc_error_count
);
    import tfd_pkg::*;

    parse_evt_t   evt;
    field_bytes_t fields;
    dec_t         dec;
    logic         dec_ready;
    logic         upd_ready;

    tfd_parser #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .byte_in   (byte_in),
        .dec_ready (dec_ready),
        .evt       (evt),
        .fields    (fields)
    );

    tfd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .fields    (fields),
        .dec_ready (dec_ready),
        .upd_ready (upd_ready),
        .dec       (dec)
    );

    tfd_update u_update (
        .clk              (clk),
        .rst_n            (rst_n),
        .dec              (dec),
        .upd_ready        (upd_ready),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .frame_status     (frame_status),
        .latitude         (latitude),
        .longitude        (longitude),
        .ground_speed     (ground_speed),
        .heading          (heading),
        .altitude         (altitude),
        .satellites       (satellites),
        .fix_kind         (fix_kind),
        .battery_voltage  (battery_voltage),
        .position_done    (position_done),
        .altitude_updated (altitude_updated),
        .crc_error_count  (crc_error_count)
    );

endmodule

`default_nettype wire
